[rtl/ihpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihpq_pkg
// Shared constants and codes for the indexed heap priority queue.
// ----------------------------------------------------------------------------
package ihpq_pkg;

  localparam int CAPACITY = 64;
  localparam int HW       = 6;   // handle and slot index width
  localparam int PW       = 32;  // priority width
  localparam int CW       = 7;   // entry count width

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

endpackage

[rtl/ihpq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihpq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ihpq_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/indexed_heap_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_heap_priority_queue
// Binary-heap priority queue of handle-addressed entries kept in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid / in_stall) carry a mode (push, pop, delete by
//   handle, update priority by handle), a handle and a priority. Each request
//   yields exactly one result on out_* (out_valid / out_stall): a status, the
//   handle allocated or popped, the root entry and the entry count.
//   cfg_wr_en / cfg_wr_data select the ordering (1: smallest on top); write
//   it only while the queue is idle.
//   Flow: a request walks the heap in slot, priority and position RAMs
//   with registered reads; a carry-down level reads both children and then
//   moves the better one up, and a sift-up level reads the parent and its
//   priority before the compare. The next request is taken in the cycle
//   after the result is loaded.
//   One request is in work at a time; in_stall is high while it runs.
//   The result sits in an output register; work stops before writing a new
//   result until the waiting one is taken.
//   Reset empties the queue, refills the free-handle stack (first push gets
//   handle 63) and clears the ordering to largest-on-top. No clearing pass.
// ----------------------------------------------------------------------------
module indexed_heap_priority_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_mode,
  input  logic [ihpq_pkg::HW-1:0] in_handle,
  input  logic [ihpq_pkg::PW-1:0] in_priority_req,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [ihpq_pkg::HW-1:0] out_result_handle,
  output logic                   out_top_valid,
  output logic [ihpq_pkg::HW-1:0] out_top_handle,
  output logic [ihpq_pkg::PW-1:0] out_top_priority,
  output logic [ihpq_pkg::CW-1:0] out_entry_count
);

  localparam int HW = ihpq_pkg::HW;
  localparam int PW = ihpq_pkg::PW;
  localparam int CW = ihpq_pkg::CW;

  typedef enum logic [4:0] {
    S_IDLE, S_PSH_RD, S_PSH_H, S_POS_RD, S_POS_H, S_RM_VR, S_RM_V, S_RM,
    S_RM_T, S_RM_TP, S_DN, S_DN_L, S_DN_R, S_DN_C, S_DN_1, S_UP, S_UP_H,
    S_UP_P, S_TOP_H, S_TOP_P, S_TOP_D, S_OUT
  } state_t;

  state_t                state_r;
  logic                  min_first_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         ft_r;
  logic [ihpq_pkg::CAPACITY-1:0] live_r;
  logic [ihpq_pkg::CAPACITY-1:0] fwr_r;
  logic [1:0]            mode_r;
  logic [HW-1:0]         hin_r;
  logic [PW-1:0]         pri_r;
  logic [1:0]            status_r;
  logic [HW-1:0]         rh_r;
  logic [HW-1:0]         hh_r;
  logic [PW-1:0]         hp_r;
  logic [HW-1:0]         hole_r;
  logic [HW-1:0]         last_r;
  logic [HW-1:0]         idx_r;
  logic [HW-1:0]         victim_r;
  logic [HW-1:0]         ph_r;
  logic [HW-1:0]         lh_r;
  logic [PW-1:0]         lp_r;
  logic [HW-1:0]         rch_r;
  logic [HW-1:0]         th_r;

  logic                  out_valid_r;
  logic [1:0]            o_status_r;
  logic [HW-1:0]         o_rh_r;
  logic                  o_tv_r;
  logic [HW-1:0]         o_th_r;
  logic [PW-1:0]         o_tp_r;
  logic [CW-1:0]         o_cnt_r;

  // ram ports
  logic          s_we, pos_we, pr_we, f_we;
  logic [HW-1:0] s_wa, s_wd, s_ra, s_rd;
  logic [HW-1:0] pos_wa, pos_wd, pos_ra, pos_rd;
  logic [HW-1:0] pr_wa, pr_ra;
  logic [PW-1:0] pr_wd, pr_rd;
  logic [HW-1:0] f_wa, f_wd, f_ra, f_rd;

  ihpq_ram #(.AW(HW), .DW(HW)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  ihpq_ram #(.AW(HW), .DW(HW)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra),
    .rdata(pos_rd)
  );
  ihpq_ram #(.AW(HW), .DW(PW)) u_prio (
    .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd)
  );
  ihpq_ram #(.AW(HW), .DW(HW)) u_free (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
  );

  function automatic logic better(input logic mf, input logic [PW-1:0] a,
                                  input logic [PW-1:0] b);
    better = mf ? (a < b) : (a > b);
  endfunction

  // heap index arithmetic
  logic [HW-1:0] parent;
  logic [HW+1:0] sc;
  logic [HW+1:0] last_ext;
  logic [HW-1:0] fidx;
  logic [HW-1:0] new_h;
  logic          in_acc;
  logic          pick_left;

  assign parent    = (hole_r - HW'(1)) >> 1;
  assign sc        = {1'b0, hole_r, 1'b0} + (HW+2)'(2);
  assign last_ext  = {2'b00, last_r};
  assign fidx      = ft_r[HW-1:0] - HW'(1);
  assign new_h     = fwr_r[fidx] ? f_rd : fidx;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign pick_left = better(min_first_r, lp_r, pr_rd);

  // memory access per state
  always_comb begin
    s_we = 1'b0; s_wa = hole_r; s_wd = hh_r; s_ra = '0;
    pos_we = 1'b0; pos_wa = hh_r; pos_wd = hole_r; pos_ra = hin_r;
    pr_we = 1'b0; pr_wa = hin_r; pr_wd = pri_r; pr_ra = s_rd;
    f_we = 1'b0; f_wa = ft_r[HW-1:0]; f_wd = victim_r; f_ra = fidx;
    unique case (state_r)
      S_PSH_H: begin
        pr_we = 1'b1; pr_wa = new_h;
      end
      S_POS_H: begin
        pr_we = (mode_r == ihpq_pkg::MODE_UPDATE);
      end
      S_RM: begin
        s_ra = count_r[HW-1:0] - HW'(1);
        f_we = 1'b1;
      end
      S_DN: begin
        s_ra = sc[HW-1:0] - HW'(1);
      end
      S_DN_L: begin
        s_ra = sc[HW-1:0];
      end
      S_DN_C: begin
        s_we = 1'b1; s_wd = pick_left ? lh_r : rch_r;
        pos_we = 1'b1; pos_wa = pick_left ? lh_r : rch_r;
      end
      S_DN_1: begin
        s_we = 1'b1; s_wd = s_rd;
        pos_we = 1'b1; pos_wa = s_rd;
      end
      S_UP: begin
        s_ra = parent;
        if (hole_r == '0) begin
          s_we = 1'b1; pos_we = 1'b1;
        end
      end
      S_UP_P: begin
        s_we = 1'b1; pos_we = 1'b1;
        if (better(min_first_r, hp_r, pr_rd)) begin
          s_wd = ph_r; pos_wa = ph_r;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_first_r <= 1'b0;
      count_r     <= '0;
      ft_r        <= CW'(ihpq_pkg::CAPACITY);
      live_r      <= '0;
      fwr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_first_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mode_r   <= in_mode;
            hin_r    <= in_handle;
            pri_r    <= in_priority_req;
            rh_r     <= '0;
            if (in_mode == ihpq_pkg::MODE_PUSH) begin
              if (count_r >= CW'(ihpq_pkg::CAPACITY) || ft_r == '0) begin
                status_r <= ihpq_pkg::ST_FULL;
                state_r  <= S_TOP_H;
              end else begin
                status_r <= ihpq_pkg::ST_OK;
                state_r  <= S_PSH_RD;
              end
            end else if (count_r == '0) begin
              status_r <= ihpq_pkg::ST_EMPTY;
              state_r  <= S_TOP_H;
            end else if (in_mode == ihpq_pkg::MODE_POP) begin
              status_r <= ihpq_pkg::ST_OK;
              state_r  <= S_RM_VR;
            end else if (!live_r[in_handle]) begin
              status_r <= ihpq_pkg::ST_UNKNOWN;
              state_r  <= S_TOP_H;
            end else begin
              status_r <= ihpq_pkg::ST_OK;
              state_r  <= S_POS_RD;
            end
          end
        end
        S_PSH_RD: state_r <= S_PSH_H;
        S_PSH_H: begin
          ft_r          <= ft_r - CW'(1);
          live_r[new_h] <= 1'b1;
          hh_r          <= new_h;
          hp_r          <= pri_r;
          rh_r          <= new_h;
          hole_r        <= count_r[HW-1:0];
          count_r       <= count_r + CW'(1);
          state_r       <= S_UP;
        end
        S_POS_RD: state_r <= S_POS_H;
        S_POS_H: begin
          idx_r    <= pos_rd;
          victim_r <= hin_r;
          hh_r     <= hin_r;
          hp_r     <= pri_r;
          hole_r   <= pos_rd;
          last_r   <= count_r[HW-1:0] - HW'(1);
          state_r  <= (mode_r == ihpq_pkg::MODE_UPDATE) ? S_DN : S_RM;
        end
        S_RM_VR: state_r <= S_RM_V;
        S_RM_V: begin
          victim_r <= s_rd;
          rh_r     <= s_rd;
          idx_r    <= '0;
          state_r  <= S_RM;
        end
        S_RM: begin
          // free the victim, then carry the tail in unless it is the tail
          live_r[victim_r]      <= 1'b0;
          fwr_r[ft_r[HW-1:0]]   <= 1'b1;
          ft_r                  <= ft_r + CW'(1);
          count_r               <= count_r - CW'(1);
          last_r                <= count_r[HW-1:0] - HW'(2);
          hole_r                <= idx_r;
          if (count_r > CW'(1) && {1'b0, idx_r} != count_r - CW'(1)) begin
            state_r <= S_RM_T;
          end else begin
            state_r <= S_TOP_H;
          end
        end
        S_RM_T: begin
          hh_r    <= s_rd;
          state_r <= S_RM_TP;
        end
        S_RM_TP: begin
          hp_r    <= pr_rd;
          state_r <= S_DN;
        end
        S_DN: begin
          if (sc <= last_ext) begin
            state_r <= S_DN_L;
          end else if (sc == last_ext + (HW+2)'(1)) begin
            state_r <= S_DN_1;
          end else begin
            state_r <= S_UP;
          end
        end
        S_DN_L: begin
          lh_r    <= s_rd;
          state_r <= S_DN_R;
        end
        S_DN_R: begin
          lp_r    <= pr_rd;
          rch_r   <= s_rd;
          state_r <= S_DN_C;
        end
        S_DN_C: begin
          hole_r  <= pick_left ? (sc[HW-1:0] - HW'(1)) : sc[HW-1:0];
          state_r <= S_DN;
        end
        S_DN_1: begin
          hole_r  <= sc[HW-1:0] - HW'(1);
          state_r <= S_UP;
        end
        S_UP: begin
          state_r <= (hole_r == '0) ? S_TOP_H : S_UP_H;
        end
        S_UP_H: begin
          ph_r    <= s_rd;
          state_r <= S_UP_P;
        end
        S_UP_P: begin
          if (better(min_first_r, hp_r, pr_rd)) begin
            hole_r  <= parent;
            state_r <= S_UP;
          end else begin
            state_r <= S_TOP_H;
          end
        end
        S_TOP_H: state_r <= S_TOP_P;
        S_TOP_P: begin
          th_r    <= s_rd;
          state_r <= S_TOP_D;
        end
        S_TOP_D: begin
          hp_r    <= pr_rd;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            o_status_r  <= status_r;
            o_rh_r      <= (mode_r == ihpq_pkg::MODE_DELETE) ? '0 : rh_r;
            o_tv_r      <= (count_r != '0);
            o_th_r      <= (count_r != '0) ? th_r : '0;
            o_tp_r      <= (count_r != '0) ? hp_r : '0;
            o_cnt_r     <= count_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_result_handle = o_rh_r;
  assign out_top_valid     = o_tv_r;
  assign out_top_handle    = o_th_r;
  assign out_top_priority  = o_tp_r;
  assign out_entry_count   = o_cnt_r;

  // checks
  a_count_free: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r + ft_r) == CW'(ihpq_pkg::CAPACITY))
    else $error("entry count and free stack out of step");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CW'(ihpq_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_valid == (out_entry_count != '0)))
    else $error("top valid disagrees with entry count");

endmodule

[dv/tb_indexed_heap_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_heap_priority_queue
// Drives push, pop, delete and update requests through the heap queue with
// random gaps and stalls, and checks every result against a behavioral heap.
// ----------------------------------------------------------------------------

class heap_scoreboard;
  logic [ihpq_pkg::HW-1:0] slot_h[ihpq_pkg::CAPACITY];
  logic [ihpq_pkg::PW-1:0] prio[ihpq_pkg::CAPACITY];
  logic [ihpq_pkg::HW-1:0] pos[ihpq_pkg::CAPACITY];
  bit                      live[ihpq_pkg::CAPACITY];
  logic [ihpq_pkg::HW-1:0] free_stack[ihpq_pkg::CAPACITY];
  int                      free_top;
  int                      count;
  bit                      min_first;
  ihpq_pkg::status_t       exp_status[$];
  logic [ihpq_pkg::HW-1:0] exp_rh[$];
  bit                      exp_tv[$];
  logic [ihpq_pkg::HW-1:0] exp_th[$];
  logic [ihpq_pkg::PW-1:0] exp_tp[$];
  logic [ihpq_pkg::CW-1:0] exp_cnt[$];
  int                      errors;

  function new();
    for (int i = 0; i < ihpq_pkg::CAPACITY; i++) begin
      free_stack[i] = ihpq_pkg::HW'(i);
      live[i] = 0;
    end
    free_top = ihpq_pkg::CAPACITY;
    count = 0;
    min_first = 0;
    errors = 0;
  endfunction

  function bit better(logic [ihpq_pkg::PW-1:0] a, logic [ihpq_pkg::PW-1:0] b);
    return min_first ? (a < b) : (a > b);
  endfunction

  function void put(int s, logic [ihpq_pkg::HW-1:0] h);
    slot_h[s] = h;
    pos[h] = ihpq_pkg::HW'(s);
  endfunction

  function void sift_up(int hole, logic [ihpq_pkg::HW-1:0] h);
    int par;
    while (hole > 0) begin
      par = (hole - 1) / 2;
      if (!better(prio[h], prio[slot_h[par]])) break;
      put(hole, slot_h[par]);
      hole = par;
    end
    put(hole, h);
  endfunction

  function void carry_down(int hole, int last, logic [ihpq_pkg::HW-1:0] h);
    int sc;
    sc = 2 * hole + 2;
    while (sc <= last) begin
      if (better(prio[slot_h[sc-1]], prio[slot_h[sc]])) sc--;
      put(hole, slot_h[sc]);
      hole = sc;
      sc = 2 * hole + 2;
    end
    if (sc == last + 1) begin
      put(hole, slot_h[sc-1]);
      hole = sc - 1;
    end
    sift_up(hole, h);
  endfunction

  function logic [ihpq_pkg::HW-1:0] remove_at(int idx);
    logic [ihpq_pkg::HW-1:0] victim;
    logic [ihpq_pkg::HW-1:0] tail;
    victim = slot_h[idx];
    if (count > 1 && idx != count - 1) begin
      tail = slot_h[count-1];
      put(count - 1, victim);
      carry_down(idx, count - 2, tail);
    end
    count--;
    live[victim] = 0;
    if (free_top < ihpq_pkg::CAPACITY) free_stack[free_top++] = victim;
    return victim;
  endfunction

  // note an accepted request and queue its expected result
  function void note_request(ihpq_pkg::mode_t m, logic [ihpq_pkg::HW-1:0] hin,
                             logic [ihpq_pkg::PW-1:0] p);
    ihpq_pkg::status_t st;
    logic [ihpq_pkg::HW-1:0] rh;
    logic [ihpq_pkg::HW-1:0] h;
    st = ihpq_pkg::ST_OK;
    rh = '0;
    if (m == ihpq_pkg::MODE_PUSH) begin
      if (free_top == 0 || count >= ihpq_pkg::CAPACITY) st = ihpq_pkg::ST_FULL;
      else begin
        h = free_stack[--free_top];
        live[h] = 1;
        prio[h] = p;
        count++;
        sift_up(count - 1, h);
        rh = h;
      end
    end else if (count == 0) st = ihpq_pkg::ST_EMPTY;
    else if (m == ihpq_pkg::MODE_POP) rh = remove_at(0);
    else if (!live[hin]) st = ihpq_pkg::ST_UNKNOWN;
    else if (m == ihpq_pkg::MODE_DELETE) void'(remove_at(pos[hin]));
    else begin
      prio[hin] = p;
      carry_down(pos[hin], count - 1, hin);
    end
    exp_status.push_back(st);
    exp_rh.push_back(rh);
    exp_tv.push_back(count > 0);
    exp_th.push_back(count > 0 ? slot_h[0] : '0);
    exp_tp.push_back(count > 0 ? prio[slot_h[0]] : '0);
    exp_cnt.push_back(ihpq_pkg::CW'(count));
  endfunction

  // compare one result with the oldest expectation
  function void check_result(logic [1:0] st, logic [ihpq_pkg::HW-1:0] rh, logic tv,
                             logic [ihpq_pkg::HW-1:0] th, logic [ihpq_pkg::PW-1:0] tp,
                             logic [ihpq_pkg::CW-1:0] cnt);
    if (exp_status.size() == 0) begin
      $error("unexpected result: status %0d", st);
      errors++;
      return;
    end
    if (st !== exp_status[0]) begin
      $error("status: expected %0d actual %0d", exp_status[0], st); errors++;
    end
    if (rh !== exp_rh[0]) begin
      $error("result_handle: expected %0d actual %0d", exp_rh[0], rh); errors++;
    end
    if (tv !== exp_tv[0]) begin
      $error("top_valid: expected %0d actual %0d", exp_tv[0], tv); errors++;
    end
    if (th !== exp_th[0]) begin
      $error("top_handle: expected %0d actual %0d", exp_th[0], th); errors++;
    end
    if (tp !== exp_tp[0]) begin
      $error("top_priority: expected %0h actual %0h", exp_tp[0], tp); errors++;
    end
    if (cnt !== exp_cnt[0]) begin
      $error("entry_count: expected %0d actual %0d", exp_cnt[0], cnt); errors++;
    end
    void'(exp_status.pop_front());
    void'(exp_rh.pop_front());
    void'(exp_tv.pop_front());
    void'(exp_th.pop_front());
    void'(exp_tp.pop_front());
    void'(exp_cnt.pop_front());
  endfunction
endclass

module tb_indexed_heap_priority_queue;
  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic                    cfg_wr_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_mode;
  logic [ihpq_pkg::HW-1:0] in_handle;
  logic [ihpq_pkg::PW-1:0] in_priority_req;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_status;
  logic [ihpq_pkg::HW-1:0] out_result_handle;
  logic                    out_top_valid;
  logic [ihpq_pkg::HW-1:0] out_top_handle;
  logic [ihpq_pkg::PW-1:0] out_top_priority;
  logic [ihpq_pkg::CW-1:0] out_entry_count;

  heap_scoreboard sb;
  bit             hold_long;
  bit             stim_done;

  indexed_heap_priority_queue u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_handle(in_handle), .in_priority_req(in_priority_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_result_handle(out_result_handle), .out_top_valid(out_top_valid),
    .out_top_handle(out_top_handle), .out_top_priority(out_top_priority),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // send one request after a random gap, hold it until accepted
  task automatic send_request(ihpq_pkg::mode_t m, logic [ihpq_pkg::HW-1:0] h,
                              logic [ihpq_pkg::PW-1:0] p, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_mode <= m;
    in_handle <= h;
    in_priority_req <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(m, h, p);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(negedge clk);
    while (sb.exp_status.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_order(bit v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.min_first = v;
  endtask

  function automatic logic [ihpq_pkg::PW-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0: return ihpq_pkg::PW'($urandom_range(0, 7));
      1: return 32'hFFFF_FFFF - ihpq_pkg::PW'($urandom_range(0, 3));
      default: return ihpq_pkg::PW'($urandom);
    endcase
  endfunction

  // mostly live handles, sometimes any handle
  function automatic logic [ihpq_pkg::HW-1:0] pick_handle();
    logic [ihpq_pkg::HW-1:0] h;
    if (sb.count > 0 && $urandom_range(0, 9) < 8)
      return sb.slot_h[$urandom_range(0, sb.count - 1)];
    h = ihpq_pkg::HW'($urandom);
    return h;
  endfunction

  task automatic random_phase(int n, int push_bias);
    ihpq_pkg::mode_t m;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_bias) m = ihpq_pkg::MODE_PUSH;
      else m = ihpq_pkg::mode_t'($urandom_range(1, 3));
      send_request(m, pick_handle(), rand_prio());
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int st;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (200) @(negedge clk);
        hold_long = 0;
      end
      st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
      if (st > 0) begin
        out_stall <= 1;
        repeat (st - 1) @(negedge clk);
      end else out_stall <= 0;
    end
  end

  // check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_result_handle, out_top_valid,
                      out_top_handle, out_top_priority, out_entry_count);
  end

  initial begin
    sb = new();
    hold_long = 0;
    stim_done = 0;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    in_valid = 0;
    in_mode = ihpq_pkg::MODE_PUSH;
    in_handle = '0;
    in_priority_req = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty heap errors, extremes, equal priorities
    send_request(ihpq_pkg::MODE_POP, 0, 0);
    send_request(ihpq_pkg::MODE_DELETE, 6'h3F, 0);
    send_request(ihpq_pkg::MODE_UPDATE, 0, 32'hFFFF_FFFF);
    send_request(ihpq_pkg::MODE_PUSH, 6'h15, 32'h0000_0000);
    send_request(ihpq_pkg::MODE_PUSH, 6'h2A, 32'hFFFF_FFFF);
    send_request(ihpq_pkg::MODE_PUSH, 0, 32'h5555_5555);
    send_request(ihpq_pkg::MODE_PUSH, 0, 32'hAAAA_AAAA);
    send_request(ihpq_pkg::MODE_PUSH, 0, 32'h5555_5555);
    send_request(ihpq_pkg::MODE_DELETE, 6'h00, 0);
    send_request(ihpq_pkg::MODE_UPDATE, 6'h3F, 32'h0000_0001);
    send_request(ihpq_pkg::MODE_UPDATE, 6'h3C, 32'hFFFF_FFFF);
    send_request(ihpq_pkg::MODE_DELETE, 6'h3B, 0);
    send_request(ihpq_pkg::MODE_DELETE, 6'h3E, 0);
    send_request(ihpq_pkg::MODE_POP, 0, 0);
    send_request(ihpq_pkg::MODE_POP, 0, 0);
    send_request(ihpq_pkg::MODE_POP, 0, 0);
    send_request(ihpq_pkg::MODE_POP, 0, 0);
    go_idle();

    // fill to capacity under a long output hold-off, then overflow
    write_order(1);
    hold_long = 1;
    for (int i = 0; i < 64; i++) send_request(ihpq_pkg::MODE_PUSH, 0, rand_prio(), 1);
    send_request(ihpq_pkg::MODE_PUSH, 0, 32'h1234_5678);
    send_request(ihpq_pkg::MODE_DELETE, 6'h3F, 0);
    random_phase(60, 30);
    go_idle();

    // order flipped with entries present
    write_order(0);
    random_phase(120, 40);
    go_idle();
    write_order(1);
    random_phase(120, 55);
    go_idle();
    write_order(0);
    random_phase(40, 25);
    in_valid <= 0;
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (sb.exp_status.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule

[indexed_heap_priority_queue.f]
rtl/ihpq_pkg.sv
rtl/ihpq_ram.sv
rtl/indexed_heap_priority_queue.sv
dv/tb_indexed_heap_priority_queue.sv
